// ----- hw/rtl/x86ild_pkg.sv -----
// Shared types, constants and opcode tables of the x86 instruction length decoder.
`default_nettype none
package x86ild_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TOTAL_W = 9;

    localparam logic [BYTE_W-1:0]  MIN_BYTES_RST = 8'd5;
    localparam logic [BYTE_W-1:0]  LEN_MAX       = 8'd255;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX     = 9'd511;

    localparam logic [7:0] OP_ESCAPE  = 8'h0F;
    localparam logic [7:0] OP_OPSIZE  = 8'h66;
    localparam logic [3:0] REX_NIBBLE = 4'h4;
    localparam int unsigned REX_W_BIT = 3;

    localparam logic [1:0] MOD_DISP0 = 2'd0;
    localparam logic [1:0] MOD_DISP8 = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG   = 2'd3;
    localparam logic [2:0] RM_SIB    = 3'd4;
    localparam logic [2:0] RM_DISP32 = 3'd5;

    typedef enum logic [5:0] {
        PH_PREFIX = 6'b000001,
        PH_OPCODE = 6'b000010,
        PH_ESCAPE = 6'b000100,
        PH_MODRM  = 6'b001000,
        PH_SIB    = 6'b010000,
        PH_TAIL   = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        CLS_UNLISTED = 2'd0,
        CLS_IMM_ONLY = 2'd1,
        CLS_MODRM    = 2'd2
    } cls_kind_t;

    typedef struct packed {
        cls_kind_t  kind;
        logic [3:0] imm;
    } cls_t;

    typedef struct packed {
        phase_t             phase;
        logic               opsize;
        logic               rex_wide;
        logic [2:0]         pend_imm;
        logic [3:0]         bytes_left;
        logic [BYTE_W-1:0]  count;
        logic [TOTAL_W-1:0] total;
        logic               finished;
    } dec_state_t;

    typedef struct packed {
        logic               done;
        logic [BYTE_W-1:0]  instr_length;
        logic [TOTAL_W-1:0] total_bytes;
        logic               enough;
    } dec_result_t;

    function automatic logic is_legacy_prefix(input logic [7:0] b);
        logic hit;
        case (b) inside
            8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65,
            8'hF0, 8'hF2, 8'hF3, 8'h66, 8'h67: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic cls_t classify(input logic [7:0] op, input logic opsize,
                                      input logic rex_wide);
        cls_t       c;
        logic [3:0] w16;
        w16    = opsize ? 4'd2 : 4'd4;
        c.kind = CLS_UNLISTED;
        c.imm  = 4'd0;
        if (op < 8'h40) begin
            case (op[2:0])
                3'd0, 3'd1, 3'd2, 3'd3: c.kind = CLS_MODRM;
                3'd4:
                begin
                    c.kind = CLS_IMM_ONLY;
                    c.imm  = 4'd1;
                end
                3'd5:
                begin
                    c.kind = CLS_IMM_ONLY;
                    c.imm  = w16;
                end
                default: c.kind = CLS_UNLISTED;
            endcase
        end else begin
            case (op) inside
                [8'h50:8'h5F], [8'h90:8'h97], 8'hC3, 8'hCC: c.kind = CLS_IMM_ONLY;
                [8'h70:8'h7F], [8'hB0:8'hB7], 8'hEB, 8'h6A, 8'hA8:
                begin
                    c.kind = CLS_IMM_ONLY;
                    c.imm  = 4'd1;
                end
                [8'hB8:8'hBF]:
                begin
                    c.kind = CLS_IMM_ONLY;
                    c.imm  = rex_wide ? 4'd8 : w16;
                end
                [8'h84:8'h8B], 8'h8D, 8'h8E, 8'h8F, 8'hFE, 8'hFF, 8'hD1, 8'hD3:
                    c.kind = CLS_MODRM;
                8'h80, 8'h82, 8'h83, 8'hC0, 8'hC1, 8'hC6, 8'h6B:
                begin
                    c.kind = CLS_MODRM;
                    c.imm  = 4'd1;
                end
                8'h81, 8'hC7, 8'h69:
                begin
                    c.kind = CLS_MODRM;
                    c.imm  = w16;
                end
                8'hC2:
                begin
                    c.kind = CLS_IMM_ONLY;
                    c.imm  = 4'd2;
                end
                8'hE8, 8'hE9, 8'h68:
                begin
                    c.kind = CLS_IMM_ONLY;
                    c.imm  = 4'd4;
                end
                8'hA9:
                begin
                    c.kind = CLS_IMM_ONLY;
                    c.imm  = w16;
                end
                default: c.kind = CLS_UNLISTED;
            endcase
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/x86ild_if.sv -----
// Valid/ready channels for code bytes in and instruction lengths out.
`default_nettype none
interface x86ild_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       routine_start;

    modport source (output valid, output code_byte, output routine_start, input ready);
    modport sink   (input valid, input code_byte, input routine_start, output ready);
endinterface

interface x86ild_len_if;
    logic       valid;
    logic       ready;
    logic [7:0] instr_length;
    logic [8:0] total_bytes;
    logic       enough;

    modport source (output valid, output instr_length, output total_bytes,
                    output enough, input ready);
    modport sink   (input valid, input instr_length, input total_bytes,
                    input enough, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/x86_instruction_length_decoder.sv -----
// Top level of the x86 instruction length decoder.
// Usage:
//   code   : sink channel, one machine-code word per handshake (code_byte plus
//            routine_start, which clears the totals and any partial instruction).
//   result : source channel, one word per completed instruction: instr_length,
//            total_bytes and enough.
//   cfg_wr_en / cfg_wr_data write min_bytes (reset value 5); write it only while
//   no word is in flight.
// Timing: an accepted word is held in the input register, decoded when it fires,
// and its result, if any, is loaded into the output register.
// Throughput is one code word per cycle while results are taken; the single phase
// machine in x86ild_step advances once per word.
// Bytes after enough is reached produce no result until routine_start.
// Reset clears the phase machine, the totals and the valid flags of both channel registers.
// When the receiver stalls with a result pending, the input register holds one
// more word and then ready drops until the result is taken.
`default_nettype none
module x86_instruction_length_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    x86ild_code_if.sink      code,
    x86ild_len_if.source     result,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data
);

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    in_start_reg;
    logic [7:0]              min_bytes_reg;
    x86ild_pkg::dec_state_t  state_reg;
    x86ild_pkg::dec_state_t  state_next;
    x86ild_pkg::dec_result_t step_res;
    logic                    out_valid_reg;
    logic [7:0]              out_len_reg;
    logic [8:0]              out_total_reg;
    logic                    out_enough_reg;
    logic                    fire;

    assign fire       = in_valid_reg && (!out_valid_reg || result.ready);
    assign code.ready = !in_valid_reg || fire;

    x86ild_step u_step (
        .state         (state_reg),
        .code_byte     (in_byte_reg),
        .routine_start (in_start_reg),
        .min_bytes     (min_bytes_reg),
        .state_next    (state_next),
        .result        (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            min_bytes_reg        <= x86ild_pkg::MIN_BYTES_RST;
            state_reg.phase      <= x86ild_pkg::PH_PREFIX;
            state_reg.opsize     <= 1'b0;
            state_reg.rex_wide   <= 1'b0;
            state_reg.pend_imm   <= 3'd0;
            state_reg.bytes_left <= 4'd0;
            state_reg.count      <= 8'd0;
            state_reg.total      <= 9'd0;
            state_reg.finished   <= 1'b0;
        end else
        begin
            if (cfg_wr_en)
            begin
                min_bytes_reg <= cfg_wr_data;
            end
            if (code.ready)
            begin
                in_valid_reg <= code.valid;
            end
            if (fire)
            begin
                state_reg <= state_next;
            end
            if (fire && step_res.done)
            begin
                out_valid_reg <= 1'b1;
            end else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: input loads on handshake, output on a new result, no reset
    always_ff @(posedge clk)
    begin
        if (code.ready && code.valid)
        begin
            in_byte_reg  <= code.code_byte;
            in_start_reg <= code.routine_start;
        end
        if (fire && step_res.done)
        begin
            out_len_reg    <= step_res.instr_length;
            out_total_reg  <= step_res.total_bytes;
            out_enough_reg <= step_res.enough;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.instr_length = out_len_reg;
    assign result.total_bytes  = out_total_reg;
    assign result.enough       = out_enough_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/x86ild_step.sv -----
// Next-state and result logic of the decoder for one code byte.
`default_nettype none
module x86ild_step (
    input  wire x86ild_pkg::dec_state_t  state,
    input  wire logic [7:0]              code_byte,
    input  wire logic                    routine_start,
    input  wire logic [7:0]              min_bytes,
    output x86ild_pkg::dec_state_t       state_next,
    output x86ild_pkg::dec_result_t      result
);

    x86ild_pkg::dec_state_t s;
    x86ild_pkg::dec_state_t n;
    x86ild_pkg::cls_t       cls;
    logic                   done;
    logic                   opcode_path;
    logic                   tail_set;
    logic [3:0]             tail_n;
    logic [3:0]             disp;
    logic [1:0]             modf;
    logic [2:0]             rm;
    logic [9:0]             sum;
    logic [8:0]             total_new;
    logic [7:0]             len_now;

    assign modf = code_byte[7:6];
    assign rm   = code_byte[2:0];

    always_comb
    begin
        s = state;
        if (routine_start)
        begin
            s.phase      = x86ild_pkg::PH_PREFIX;
            s.opsize     = 1'b0;
            s.rex_wide   = 1'b0;
            s.pend_imm   = 3'd0;
            s.bytes_left = 4'd0;
            s.count      = 8'd0;
            s.total      = 9'd0;
            s.finished   = 1'b0;
        end

        cls         = x86ild_pkg::classify(code_byte, s.opsize, s.rex_wide);
        n           = s;
        done        = 1'b0;
        opcode_path = 1'b0;
        tail_set    = 1'b0;
        tail_n      = 4'd0;
        disp        = 4'd0;
        sum         = 10'd0;
        total_new   = s.total;

        if (s.count != x86ild_pkg::LEN_MAX)
        begin
            n.count = s.count + 8'd1;
        end

        case (s.phase)
            x86ild_pkg::PH_PREFIX:
            begin
                if (x86ild_pkg::is_legacy_prefix(code_byte))
                begin
                    if (code_byte == x86ild_pkg::OP_OPSIZE)
                    begin
                        n.opsize = 1'b1;
                    end
                end else if (code_byte[7:4] == x86ild_pkg::REX_NIBBLE)
                begin
                    n.rex_wide = code_byte[x86ild_pkg::REX_W_BIT];
                    n.phase    = x86ild_pkg::PH_OPCODE;
                end else
                begin
                    opcode_path = 1'b1;
                end
            end
            x86ild_pkg::PH_OPCODE:
            begin
                opcode_path = 1'b1;
            end
            x86ild_pkg::PH_ESCAPE:
            begin
                // 0F 80..8F: near jcc with rel32, no ModR/M
                if (code_byte inside {[8'h80:8'h8F]})
                begin
                    tail_set = 1'b1;
                    tail_n   = 4'd4;
                end else
                begin
                    n.pend_imm = 3'd0;
                    n.phase    = x86ild_pkg::PH_MODRM;
                end
            end
            x86ild_pkg::PH_MODRM:
            begin
                case (modf)
                    x86ild_pkg::MOD_DISP8:  disp = 4'd1;
                    x86ild_pkg::MOD_DISP32: disp = 4'd4;
                    default:                disp = 4'd0;
                endcase
                if (modf == x86ild_pkg::MOD_DISP0 && rm == x86ild_pkg::RM_DISP32)
                begin
                    disp = 4'd4;
                end
                if (modf != x86ild_pkg::MOD_REG && rm == x86ild_pkg::RM_SIB)
                begin
                    // park the displacement size until the SIB byte is seen
                    n.bytes_left = disp;
                    n.phase      = x86ild_pkg::PH_SIB;
                end else
                begin
                    tail_set = 1'b1;
                    tail_n   = disp + {1'b0, s.pend_imm};
                end
            end
            x86ild_pkg::PH_SIB:
            begin
                disp = s.bytes_left;
                if (disp == 4'd0 && rm == x86ild_pkg::RM_DISP32)
                begin
                    disp = 4'd4;
                end
                tail_set = 1'b1;
                tail_n   = disp + {1'b0, s.pend_imm};
            end
            x86ild_pkg::PH_TAIL:
            begin
                if (s.bytes_left != 4'd0)
                begin
                    n.bytes_left = s.bytes_left - 4'd1;
                end
                done = (n.bytes_left == 4'd0);
            end
            default:
            begin
                done = 1'b1;
            end
        endcase

        if (opcode_path)
        begin
            if (code_byte == x86ild_pkg::OP_ESCAPE)
            begin
                n.phase = x86ild_pkg::PH_ESCAPE;
            end else
            begin
                case (cls.kind)
                    x86ild_pkg::CLS_IMM_ONLY:
                    begin
                        tail_set = 1'b1;
                        tail_n   = cls.imm;
                    end
                    x86ild_pkg::CLS_MODRM:
                    begin
                        n.pend_imm = cls.imm[2:0];
                        n.phase    = x86ild_pkg::PH_MODRM;
                    end
                    default:
                    begin
                        done = 1'b1;
                    end
                endcase
            end
        end

        if (tail_set)
        begin
            n.bytes_left = tail_n;
            if (tail_n == 4'd0)
            begin
                done = 1'b1;
            end else
            begin
                n.phase = x86ild_pkg::PH_TAIL;
            end
        end

        // hold the length before the instruction state is cleared
        len_now = n.count;

        if (done)
        begin
            sum       = {1'b0, s.total} + {2'b00, n.count};
            total_new = sum[9] ? x86ild_pkg::TOTAL_MAX : sum[8:0];
            n.total      = total_new;
            n.finished   = (total_new >= {1'b0, min_bytes});
            n.phase      = x86ild_pkg::PH_PREFIX;
            n.opsize     = 1'b0;
            n.rex_wide   = 1'b0;
            n.pend_imm   = 3'd0;
            n.bytes_left = 4'd0;
            n.count      = 8'd0;
        end

        // drop bytes once the routine has covered enough
        if (s.finished)
        begin
            n    = s;
            done = 1'b0;
        end

        state_next          = n;
        result.done         = done;
        result.instr_length = len_now;
        result.total_bytes  = total_new;
        result.enough       = n.finished;
    end

endmodule
`default_nettype wire
